[src/mbb_pkg.sv]
// Package for the motion bounding box block: sizes, register indexes,
// the queue entry and geometry types, and the frame size clamp.
// No dependencies; every other file in src imports it.
package mbb_pkg;

  localparam int MAX_DIM   = 4096;
  localparam int POS_W     = $clog2(MAX_DIM);
  localparam int DIM_W     = POS_W + 1;
  localparam int CFG_W     = 13;
  localparam int MARGIN_W  = 8;
  localparam int COUNT_W   = 23;
  localparam int PIXEL_W   = 8;
  localparam int IDX_W     = 2;
  localparam int PAD_W     = ((DIM_W > MARGIN_W) ? DIM_W : MARGIN_W) + 1;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);

  localparam logic [PIXEL_W-1:0]  MARK_VALUE     = PIXEL_W'(255);
  localparam logic [CFG_W-1:0]    RESET_WIDTH    = CFG_W'(640);
  localparam logic [CFG_W-1:0]    RESET_HEIGHT   = CFG_W'(480);
  localparam logic [MARGIN_W-1:0] RESET_MARGIN   = MARGIN_W'(10);

  typedef enum logic [IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_PAD_MARGIN   = 2'd2
  } reg_index_t;

  // Effective frame geometry after clamping; w_last and h_last are size minus one.
  typedef struct packed {
    logic [DIM_W-1:0]    width;
    logic [DIM_W-1:0]    height;
    logic [DIM_W-1:0]    w_last;
    logic [DIM_W-1:0]    h_last;
    logic [MARGIN_W-1:0] margin;
  } geom_t;

  // One classified pixel handed from the front end to the back end.
  typedef struct packed {
    logic             mark;
    logic             frame_end;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
  } event_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v < CFG_W'(2)) begin
      r = DIM_W'(2);
    end else if (int'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  localparam logic [DIM_W-1:0] RESET_W_CLAMPED = clamp_dim(RESET_WIDTH);
  localparam logic [DIM_W-1:0] RESET_H_CLAMPED = clamp_dim(RESET_HEIGHT);

endpackage

[src/motion_bounding_box_top.sv]
// Top level of the motion bounding box block: configuration registers,
// front end, request queue and back end. Depends on mbb_pkg, mbb_front,
// mbb_fifo and mbb_back.
//
// Usage: pixels of a binary difference image enter in raster order on the
// in_valid/in_ready channel, one request per pixel. The block keeps its own
// column and row counters; only pixels on even rows and even columns are
// examined, and those equal to 255 are counted and widen the box.
// On the last pixel of each frame one result request leaves on the
// out_valid/out_ready channel: found flag, saturating count and the padded
// box. The block sustains one pixel per clock while the queue has room. With
// a free output, the last pixel of a frame is written into the queue as an
// entry, and once that entry reaches the head it is drained into the back
// end's result register, which presents the result.
// Frame size and pad margin are written through cfg_we/cfg_index/cfg_data;
// sizes are clamped into 2 to 4096. Reset loads 640 by 480 with a margin of
// 10, clears the counters and the queue, and drops any pending result.
// When the receiver stalls, the result is held in its register; the front
// end keeps taking pixels, and only marked pixels and the next frame end
// enter the four-entry queue, so in_ready falls only once that queue fills.
module motion_bounding_box_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [mbb_pkg::IDX_W-1:0]   cfg_index,
  input  logic [mbb_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [mbb_pkg::PIXEL_W-1:0] pixel_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        box_found,
  output logic [mbb_pkg::COUNT_W-1:0] changed_count,
  output logic [mbb_pkg::POS_W-1:0]   box_left,
  output logic [mbb_pkg::POS_W-1:0]   box_top,
  output logic [mbb_pkg::POS_W-1:0]   box_right,
  output logic [mbb_pkg::POS_W-1:0]   box_bottom
);
  import mbb_pkg::*;

  logic [CFG_W-1:0]    frame_width;
  logic [CFG_W-1:0]    frame_height;
  logic [MARGIN_W-1:0] pad_margin;
  geom_t               geom;

  logic   q_push;
  event_t q_data;
  logic   q_full;
  logic   q_pop;
  logic   q_valid;
  event_t q_head;

  // Configuration registers; writes to the unused index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RESET_WIDTH;
      frame_height <= RESET_HEIGHT;
      pad_margin   <= RESET_MARGIN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        REG_PAD_MARGIN:   pad_margin   <= cfg_data[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective geometry, shared by both ends of the queue.
  always_comb begin
    geom.width  = clamp_dim(frame_width);
    geom.height = clamp_dim(frame_height);
    geom.w_last = geom.width - 1'b1;
    geom.h_last = geom.height - 1'b1;
    geom.margin = pad_margin;
  end

  mbb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .geom        (geom),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel_value (pixel_value),
    .q_push      (q_push),
    .q_data      (q_data),
    .q_full      (q_full)
  );

  mbb_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  mbb_back u_back (
    .clk           (clk),
    .rst           (rst),
    .geom          (geom),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .box_found     (box_found),
    .changed_count (changed_count),
    .box_left      (box_left),
    .box_top       (box_top),
    .box_right     (box_right),
    .box_bottom    (box_bottom)
  );

endmodule

[src/mbb_front.sv]
// Front end: raster position counters and pixel classification.
// Depends on mbb_pkg; feeds mbb_fifo with marked pixels and frame ends.
module mbb_front (
  input  logic                        clk,
  input  logic                        rst,
  input  mbb_pkg::geom_t              geom,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [mbb_pkg::PIXEL_W-1:0] pixel_value,
  output logic                        q_push,
  output mbb_pkg::event_t             q_data,
  input  logic                        q_full
);
  import mbb_pkg::*;

  logic [POS_W-1:0] col;
  logic [POS_W-1:0] row;
  logic             accept;
  logic             row_end;
  logic             frame_end;
  logic             mark;

  assign in_ready  = !q_full;
  assign accept    = in_valid && !q_full;
  assign row_end   = DIM_W'(col) >= geom.w_last;
  assign frame_end = row_end && (DIM_W'(row) >= geom.h_last);
  assign mark      = !col[0] && !row[0] && (pixel_value == MARK_VALUE);

  // Pixels that neither mark nor close a frame leave no trace downstream.
  assign q_push         = accept && (mark || frame_end);
  assign q_data.mark      = mark;
  assign q_data.frame_end = frame_end;
  assign q_data.col       = col;
  assign q_data.row       = row;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (frame_end) begin
        col <= '0;
        row <= '0;
      end else if (row_end) begin
        col <= '0;
        row <= row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

endmodule

[src/mbb_fifo.sv]
// Short queue of classified pixels between front end and back end.
// Depends on mbb_pkg for the entry type and depth.
module mbb_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mbb_pkg::event_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output mbb_pkg::event_t head
);
  import mbb_pkg::*;

  event_t            entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = count == (QPTR_W+1)'(QDEPTH);
  assign valid = count != '0;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> valid) else $error("queue read while empty");

endmodule

[src/mbb_back.sv]
// Back end: running bounding box and match count, padding at frame end,
// and the result register. Depends on mbb_pkg; drains mbb_fifo.
module mbb_back (
  input  logic                        clk,
  input  logic                        rst,
  input  mbb_pkg::geom_t              geom,
  input  logic                        q_valid,
  input  mbb_pkg::event_t             q_head,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        box_found,
  output logic [mbb_pkg::COUNT_W-1:0] changed_count,
  output logic [mbb_pkg::POS_W-1:0]   box_left,
  output logic [mbb_pkg::POS_W-1:0]   box_top,
  output logic [mbb_pkg::POS_W-1:0]   box_right,
  output logic [mbb_pkg::POS_W-1:0]   box_bottom
);
  import mbb_pkg::*;

  logic [DIM_W-1:0]   least_col;
  logic [POS_W-1:0]   greatest_col;
  logic [DIM_W-1:0]   least_row;
  logic [POS_W-1:0]   greatest_row;
  logic [COUNT_W-1:0] tally;

  logic [DIM_W-1:0]   lc_next;
  logic [POS_W-1:0]   gc_next;
  logic [DIM_W-1:0]   lr_next;
  logic [POS_W-1:0]   gr_next;
  logic [COUNT_W-1:0] tally_next;
  logic               found;
  logic [PAD_W-1:0]   margin_x;
  logic [PAD_W-1:0]   left_sum;
  logic [PAD_W-1:0]   top_sum;
  logic [PAD_W-1:0]   right_sum;
  logic [PAD_W-1:0]   bottom_sum;
  logic [POS_W-1:0]   pad_left;
  logic [POS_W-1:0]   pad_top;
  logic [POS_W-1:0]   pad_right;
  logic [POS_W-1:0]   pad_bottom;
  logic               pop_end;

  // A frame end needs the result register; plain marks never wait.
  assign q_pop   = q_valid && (!q_head.frame_end || !out_valid || out_ready);
  assign pop_end = q_pop && q_head.frame_end;

  always_comb begin
    lc_next    = (q_head.mark && (DIM_W'(q_head.col) < least_col)) ?
                 DIM_W'(q_head.col) : least_col;
    gc_next    = (q_head.mark && (q_head.col > greatest_col)) ? q_head.col : greatest_col;
    lr_next    = (q_head.mark && (DIM_W'(q_head.row) < least_row)) ?
                 DIM_W'(q_head.row) : least_row;
    gr_next    = (q_head.mark && (q_head.row > greatest_row)) ? q_head.row : greatest_row;
    tally_next = (q_head.mark && (tally != '1)) ? tally + 1'b1 : tally;
    found      = tally_next != '0;

    // Each edge moves outward only while it stays strictly inside the frame.
    margin_x   = PAD_W'(geom.margin);
    left_sum   = PAD_W'(lc_next) - margin_x;
    top_sum    = PAD_W'(lr_next) - margin_x;
    right_sum  = PAD_W'(gc_next) + margin_x;
    bottom_sum = PAD_W'(gr_next) + margin_x;
    pad_left   = (PAD_W'(lc_next) > margin_x) ? POS_W'(left_sum) : POS_W'(lc_next);
    pad_top    = (PAD_W'(lr_next) > margin_x) ? POS_W'(top_sum) : POS_W'(lr_next);
    pad_right  = (right_sum < PAD_W'(geom.w_last)) ? POS_W'(right_sum) : gc_next;
    pad_bottom = (bottom_sum < PAD_W'(geom.h_last)) ? POS_W'(bottom_sum) : gr_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      least_col    <= RESET_W_CLAMPED;
      greatest_col <= '0;
      least_row    <= RESET_H_CLAMPED;
      greatest_row <= '0;
      tally        <= '0;
    end else if (pop_end) begin
      least_col    <= geom.width;
      greatest_col <= '0;
      least_row    <= geom.height;
      greatest_row <= '0;
      tally        <= '0;
    end else if (q_pop) begin
      least_col    <= lc_next;
      greatest_col <= gc_next;
      least_row    <= lr_next;
      greatest_row <= gr_next;
      tally        <= tally_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_end) begin
      box_found     <= found;
      changed_count <= tally_next;
      box_left      <= found ? pad_left : '0;
      box_top       <= found ? pad_top : '0;
      box_right     <= found ? pad_right : '0;
      box_bottom    <= found ? pad_bottom : '0;
    end
  end

  a_found_matches_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (box_found == (changed_count != '0)))
    else $error("found flag disagrees with count");
  a_box_ordered: assert property (@(posedge clk) disable iff (rst)
    (out_valid && box_found) |-> ((box_left <= box_right) && (box_top <= box_bottom)))
    else $error("box edges out of order");
  a_empty_box_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !box_found) |->
      ((box_left == '0) && (box_top == '0) && (box_right == '0) && (box_bottom == '0)))
    else $error("empty frame reported a nonzero box");

endmodule
